### rtl/core/impt_pkg.sv
// impt_pkg: shared constants, command and register codes, microcode word
// layout and the control store of the in-place transpose core.
// No dependencies; used by impt_seq, impt_datapath and the top level.
package impt_pkg;

	localparam int MAX_DIM_DEF   = 32;
	localparam int WORD_BITS_DEF = 64;

	localparam int DATA_W    = 64;
	localparam int CFG_W     = 6;
	localparam int RC_W      = 5;
	localparam int CMD_W     = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_XPOSE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_ACCESS = 4'd1;
	localparam step_t ST_EMIT   = 4'd2;
	localparam step_t ST_LAST   = 4'd3;
	localparam step_t ST_CLEAR  = 4'd4;
	localparam step_t ST_SCAN   = 4'd5;
	localparam step_t ST_MARK   = 4'd6;
	localparam step_t ST_DIV    = 4'd7;
	localparam step_t ST_DIVW   = 4'd8;
	localparam step_t ST_NEXT   = 4'd9;
	localparam step_t ST_FETCH  = 4'd10;
	localparam step_t ST_MOVE   = 4'd11;
	localparam step_t ST_CLOSE  = 4'd12;
	localparam step_t ST_ADV    = 4'd13;
	localparam step_t ST_FLIP   = 4'd14;
	localparam step_t ST_XEMIT  = 4'd15;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAKE,
		OP_ACCESS,
		OP_EMIT,
		OP_LOAD_LAST,
		OP_CLEAR,
		OP_SCAN,
		OP_MARK,
		OP_DIV_START,
		OP_NEXT,
		OP_FETCH,
		OP_MOVE,
		OP_CLOSE,
		OP_START_INC,
		OP_FLIP
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_ITEM,
		C_XPOSE,
		C_CLR_DONE,
		C_START_DONE,
		C_VISITED,
		C_DIV_DONE,
		C_NXT_START,
		C_OUT_FREE
	} cond_sel_t;

	// on a hit go to target, otherwise hold the step (stay) or fall through
	typedef struct packed {
		op_t       op;
		cond_sel_t cond;
		logic      stay;
		step_t     target;
	} uword_t;

	typedef struct packed {
		logic item;
		logic xpose;
		logic clr_done;
		logic start_done;
		logic visited;
		logic div_done;
		logic nxt_start;
		logic out_free;
	} flags_t;

	function automatic uword_t uw(input op_t o, input cond_sel_t c, input logic st,
		input step_t t);
		uword_t w;
		w.op     = o;
		w.cond   = c;
		w.stay   = st;
		w.target = t;
		return w;
	endfunction

	function automatic uword_t ucode_rom(input step_t s);
		uword_t w;
		unique case (s)
			ST_IDLE:   w = uw(OP_TAKE,      C_ITEM,       1'b1, ST_ACCESS);
			ST_ACCESS: w = uw(OP_ACCESS,    C_XPOSE,      1'b0, ST_LAST);
			ST_EMIT:   w = uw(OP_EMIT,      C_OUT_FREE,   1'b1, ST_IDLE);
			ST_LAST:   w = uw(OP_LOAD_LAST, C_NEVER,      1'b0, ST_IDLE);
			ST_CLEAR:  w = uw(OP_CLEAR,     C_CLR_DONE,   1'b1, ST_SCAN);
			ST_SCAN:   w = uw(OP_SCAN,      C_START_DONE, 1'b0, ST_FLIP);
			ST_MARK:   w = uw(OP_MARK,      C_VISITED,    1'b0, ST_ADV);
			ST_DIV:    w = uw(OP_DIV_START, C_NEVER,      1'b0, ST_IDLE);
			ST_DIVW:   w = uw(OP_NONE,      C_DIV_DONE,   1'b1, ST_NEXT);
			ST_NEXT:   w = uw(OP_NEXT,      C_NEVER,      1'b0, ST_IDLE);
			ST_FETCH:  w = uw(OP_FETCH,     C_NXT_START,  1'b0, ST_CLOSE);
			ST_MOVE:   w = uw(OP_MOVE,      C_ALWAYS,     1'b0, ST_DIV);
			ST_CLOSE:  w = uw(OP_CLOSE,     C_NEVER,      1'b0, ST_IDLE);
			ST_ADV:    w = uw(OP_START_INC, C_ALWAYS,     1'b0, ST_SCAN);
			ST_FLIP:   w = uw(OP_FLIP,      C_NEVER,      1'b0, ST_IDLE);
			ST_XEMIT:  w = uw(OP_EMIT,      C_OUT_FREE,   1'b1, ST_IDLE);
			default:   w = uw(OP_NONE,      C_ALWAYS,     1'b0, ST_IDLE);
		endcase
		return w;
	endfunction

endpackage

### rtl/core/impt_div.sv
// impt_div: restoring divider, one quotient bit per cycle, splits a store
// index into quotient and remainder by the current row count.
// Depends on impt_pkg only through the parent's parameters.
module impt_div #(
	parameter int MAX_DIM = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  go,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    dividend,
	input  logic [$clog2(MAX_DIM+1)-1:0]          divisor,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    quotient,
	output logic [$clog2(MAX_DIM+1)-1:0]          remainder,
	output logic                                  busy
);

	localparam int DIM_W = $clog2(MAX_DIM+1);
	localparam int IDX_W = $clog2(MAX_DIM*MAX_DIM);
	localparam int CNT_W = $clog2(IDX_W+1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] quo_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W-1:0] dvs_q;
	logic [DIM_W:0]   trial;
	logic [DIM_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[IDX_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(IDX_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[IDX_W-2:0], fits};
			rem_q <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign busy      = busy_q;

endmodule

### rtl/core/impt_seq.sv
// impt_seq: microcode sequencer with step counter, control store lookup
// and conditional jump select.
// Depends on impt_pkg (control store, word and flag types).
module impt_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  impt_pkg::flags_t flags,
	output impt_pkg::uword_t ctrl
);

	impt_pkg::step_t  step_q;
	impt_pkg::step_t  step_d;
	impt_pkg::uword_t word;
	logic             hit;

	assign word = impt_pkg::ucode_rom(step_q);
	assign ctrl = word;

	always_comb begin
		unique case (word.cond)
			impt_pkg::C_NEVER:      hit = 1'b0;
			impt_pkg::C_ALWAYS:     hit = 1'b1;
			impt_pkg::C_ITEM:       hit = flags.item;
			impt_pkg::C_XPOSE:      hit = flags.xpose;
			impt_pkg::C_CLR_DONE:   hit = flags.clr_done;
			impt_pkg::C_START_DONE: hit = flags.start_done;
			impt_pkg::C_VISITED:    hit = flags.visited;
			impt_pkg::C_DIV_DONE:   hit = flags.div_done;
			impt_pkg::C_NXT_START:  hit = flags.nxt_start;
			impt_pkg::C_OUT_FREE:   hit = flags.out_free;
			default:                hit = 1'b0;
		endcase
		if (hit) begin
			step_d = word.target;
		end else if (word.stay) begin
			step_d = step_q;
		end else begin
			step_d = step_q + impt_pkg::step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= impt_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

### rtl/core/impt_datapath.sv
// impt_datapath: element store, visited map, index registers, word capture
// and result register, all driven by the microcode word.
// Depends on impt_pkg and impt_div.
module impt_datapath #(
	parameter int MAX_DIM   = 32,
	parameter int WORD_BITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  impt_pkg::uword_t                   ctrl,
	output impt_pkg::flags_t                   flags,
	input  logic [$clog2(MAX_DIM+1)-1:0]       r_dim,
	input  logic [$clog2(MAX_DIM+1)-1:0]       c_dim,
	output logic                               flipped,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [impt_pkg::CMD_W-1:0]         cmd,
	input  logic [impt_pkg::RC_W-1:0]          row_index,
	input  logic [impt_pkg::RC_W-1:0]          col_index,
	input  logic [impt_pkg::DATA_W-1:0]        write_value,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               ok,
	output logic [impt_pkg::DATA_W-1:0]        read_value,
	output logic                               is_transposed
);

	localparam int DIM_W  = $clog2(MAX_DIM+1);
	localparam int DEPTH  = MAX_DIM*MAX_DIM;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int PRD_W  = 2*DIM_W;
	localparam int RC_W   = impt_pkg::RC_W;
	localparam int LIN_W  = RC_W + DIM_W + 1;
	localparam int CMP_W  = (RC_W > DIM_W) ? RC_W : DIM_W;
	localparam int DATA_W = impt_pkg::DATA_W;

	logic [WORD_BITS-1:0] elem_mem [DEPTH];
	logic                 vis_mem  [DEPTH];

	logic [impt_pkg::CMD_W-1:0] cmd_q;
	logic [RC_W-1:0]            row_q;
	logic [RC_W-1:0]            col_q;
	logic [WORD_BITS-1:0]       wval_q;
	logic [IDX_W-1:0]           last_q;
	logic [IDX_W-1:0]           clr_q;
	logic [IDX_W-1:0]           start_q;
	logic [IDX_W-1:0]           cur_q;
	logic [IDX_W-1:0]           nxt_q;
	logic [WORD_BITS-1:0]       hold_q;
	logic [WORD_BITS-1:0]       edata_q;
	logic                       vdata_q;
	logic                       flag_q;
	logic                       result_valid_q;
	logic                       ok_q;
	logic [WORD_BITS-1:0]       rdata_q;
	logic                       xposed_q;

	logic                 accept;
	logic                 in_range;
	logic                 is_rw;
	logic [LIN_W-1:0]     lin;
	logic [IDX_W-1:0]     lin_idx;
	logic [PRD_W-1:0]     area;
	logic [PRD_W-1:0]     nxt_sum;
	logic                 out_free;
	logic                 emit;
	logic                 clr_done;
	logic                 start_done;
	logic                 nxt_start;

	logic                 e_we;
	logic [IDX_W-1:0]     e_waddr;
	logic [WORD_BITS-1:0] e_wdata;
	logic                 e_re;
	logic [IDX_W-1:0]     e_raddr;
	logic                 v_we;
	logic [IDX_W-1:0]     v_waddr;
	logic                 v_wbit;
	logic                 v_re;

	logic                 div_go;
	logic [IDX_W-1:0]     div_quo;
	logic [DIM_W-1:0]     div_rem;
	logic                 div_busy;

	impt_div #(
		.MAX_DIM(MAX_DIM)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (cur_q),
		.divisor  (r_dim),
		.quotient (div_quo),
		.remainder(div_rem),
		.busy     (div_busy)
	);

	assign item_stall = (ctrl.op != impt_pkg::OP_TAKE);
	assign accept     = item_valid && !item_stall;

	assign in_range = (CMP_W'(row_q) < CMP_W'(r_dim)) && (CMP_W'(col_q) < CMP_W'(c_dim));
	assign is_rw    = (cmd_q == impt_pkg::CMD_READ) || (cmd_q == impt_pkg::CMD_WRITE);
	assign lin      = LIN_W'(row_q) * LIN_W'(c_dim) + LIN_W'(col_q);
	assign lin_idx  = IDX_W'(lin);
	assign area     = PRD_W'(r_dim) * PRD_W'(c_dim) - PRD_W'(1);
	// position (p, q) of index i = q*R + p moves to p*C + q
	assign nxt_sum  = PRD_W'(div_rem) * PRD_W'(c_dim) + PRD_W'(div_quo);

	assign clr_done   = (clr_q == last_q);
	assign start_done = (start_q == last_q);
	assign nxt_start  = (nxt_q == start_q);
	assign out_free   = !result_valid_q || !result_stall;
	assign emit       = (ctrl.op == impt_pkg::OP_EMIT) && out_free;

	assign flags.item       = accept;
	assign flags.xpose      = (cmd_q == impt_pkg::CMD_XPOSE);
	assign flags.clr_done   = clr_done;
	assign flags.start_done = start_done;
	assign flags.visited    = vdata_q;
	assign flags.div_done   = !div_busy;
	assign flags.nxt_start  = nxt_start;
	assign flags.out_free   = out_free;

	always_comb begin
		e_we    = 1'b0;
		e_waddr = cur_q;
		e_wdata = edata_q;
		e_re    = 1'b0;
		e_raddr = start_q;
		v_we    = 1'b0;
		v_waddr = cur_q;
		v_wbit  = 1'b1;
		v_re    = 1'b0;
		div_go  = 1'b0;
		unique case (ctrl.op)
			impt_pkg::OP_ACCESS: begin
				e_re    = in_range && (cmd_q == impt_pkg::CMD_READ);
				e_raddr = lin_idx;
				e_we    = in_range && (cmd_q == impt_pkg::CMD_WRITE);
				e_waddr = lin_idx;
				e_wdata = wval_q;
			end
			impt_pkg::OP_CLEAR: begin
				v_we    = !clr_done;
				v_waddr = clr_q;
				v_wbit  = 1'b0;
			end
			impt_pkg::OP_SCAN: begin
				e_re = !start_done;
				v_re = !start_done;
			end
			impt_pkg::OP_MARK: begin
				v_we = 1'b1;
			end
			impt_pkg::OP_DIV_START: begin
				div_go = 1'b1;
			end
			impt_pkg::OP_FETCH: begin
				e_re    = !nxt_start;
				e_raddr = nxt_q;
			end
			impt_pkg::OP_MOVE: begin
				e_we    = 1'b1;
				v_we    = 1'b1;
				v_waddr = nxt_q;
			end
			impt_pkg::OP_CLOSE: begin
				e_we    = 1'b1;
				e_wdata = hold_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (e_we) begin
			elem_mem[e_waddr] <= e_wdata;
		end
		if (e_re) begin
			edata_q <= elem_mem[e_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			vis_mem[v_waddr] <= v_wbit;
		end
		if (v_re) begin
			vdata_q <= vis_mem[start_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			row_q  <= row_index;
			col_q  <= col_index;
			wval_q <= write_value[WORD_BITS-1:0];
		end
		case (ctrl.op)
			impt_pkg::OP_LOAD_LAST: begin
				last_q  <= IDX_W'(area);
				clr_q   <= '0;
				start_q <= '0;
			end
			impt_pkg::OP_CLEAR: begin
				if (!clr_done) begin
					clr_q <= clr_q + IDX_W'(1);
				end
			end
			impt_pkg::OP_SCAN:      cur_q   <= start_q;
			impt_pkg::OP_MARK:      hold_q  <= edata_q;
			impt_pkg::OP_NEXT:      nxt_q   <= IDX_W'(nxt_sum);
			impt_pkg::OP_MOVE:      cur_q   <= nxt_q;
			impt_pkg::OP_START_INC: start_q <= start_q + IDX_W'(1);
			default: begin
			end
		endcase
		if (emit) begin
			ok_q     <= (cmd_q == impt_pkg::CMD_XPOSE) || (is_rw && in_range);
			rdata_q  <= (in_range && (cmd_q == impt_pkg::CMD_READ)) ? edata_q : '0;
			xposed_q <= flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == impt_pkg::OP_FLIP) begin
				flag_q <= !flag_q;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign flipped       = flag_q;
	assign result_valid  = result_valid_q;
	assign ok            = ok_q;
	assign read_value    = DATA_W'(rdata_q);
	assign is_transposed = xposed_q;

endmodule

### rtl/core/in_place_matrix_transpose_core.sv
// in_place_matrix_transpose_core: top level of the in-place transpose core;
// shape registers, shape clamping and the sequencer and datapath instances.
// Depends on impt_pkg, impt_seq, impt_datapath.
//
//   channel | handshake                | word
//   --------+--------------------------+----------------------------------------
//   item    | item_valid / item_stall  | cmd, row_index, col_index, write_value
//   result  | result_valid / result_stall | ok, read_value, is_transposed
//   cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// read and write go through capture, one store access and result load per word
// transpose of an R x C shape runs the visited-map clear, a scan of each start
// index, and for each moved element a pass of the bit-serial divider that finds
// each next index
// reset: shape 1 x 1, transposed flag and result valid cleared, no clearing pass
// a stalled result holds; the next word is still taken and waits at emit
module in_place_matrix_transpose_core #(
	parameter int MAX_DIM   = impt_pkg::MAX_DIM_DEF,
	parameter int WORD_BITS = impt_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [impt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [impt_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [impt_pkg::CMD_W-1:0]      cmd,
	input  logic [impt_pkg::RC_W-1:0]       row_index,
	input  logic [impt_pkg::RC_W-1:0]       col_index,
	input  logic [impt_pkg::DATA_W-1:0]     write_value,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            ok,
	output logic [impt_pkg::DATA_W-1:0]     read_value,
	output logic                            is_transposed
);

	localparam int DIM_W = $clog2(MAX_DIM+1);
	localparam int CFG_W = impt_pkg::CFG_W;
	localparam int CMP_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

	logic [CFG_W-1:0]  row_count_q;
	logic [CFG_W-1:0]  column_count_q;
	logic [DIM_W-1:0]  row_eff;
	logic [DIM_W-1:0]  col_eff;
	logic [DIM_W-1:0]  r_dim;
	logic [DIM_W-1:0]  c_dim;
	logic              flipped;

	impt_pkg::uword_t  ctrl;
	impt_pkg::flags_t  flags;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] d;
		if (v == '0) begin
			d = DIM_W'(1);
		end else if (CMP_W'(v) > CMP_W'(MAX_DIM)) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = DIM_W'(v);
		end
		return d;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= CFG_W'(1);
			column_count_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				impt_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data;
				impt_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign row_eff = clamp_dim(row_count_q);
	assign col_eff = clamp_dim(column_count_q);
	assign r_dim   = flipped ? col_eff : row_eff;
	assign c_dim   = flipped ? row_eff : col_eff;

	impt_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.ctrl  (ctrl)
	);

	impt_datapath #(
		.MAX_DIM  (MAX_DIM),
		.WORD_BITS(WORD_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.flags        (flags),
		.r_dim        (r_dim),
		.c_dim        (c_dim),
		.flipped      (flipped),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.row_index    (row_index),
		.col_index    (col_index),
		.write_value  (write_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ok           (ok),
		.read_value   (read_value),
		.is_transposed(is_transposed)
	);

endmodule
